>>> design/metp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mandelbrot escape-time pixel block
// no dependencies

package metp_pkg;

	// register file layout
	localparam int ITER_BITS     = 8;
	localparam int SCALE_BITS    = 16;
	localparam int CENTER_BITS   = 8;
	localparam int REG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [REG_IDX_BITS-1:0] metp_reg_idx_t;

	localparam metp_reg_idx_t REG_MAX_ITER   = 3'd0;
	localparam metp_reg_idx_t REG_SCALE_X    = 3'd1;
	localparam metp_reg_idx_t REG_SCALE_Y    = 3'd2;
	localparam metp_reg_idx_t REG_CENTER_COL = 3'd3;
	localparam metp_reg_idx_t REG_CENTER_ROW = 3'd4;

	localparam logic [ITER_BITS-1:0]   RST_MAX_ITER   = 8'd60;
	localparam logic [SCALE_BITS-1:0]  RST_SCALE_X    = 16'd40;
	localparam logic [SCALE_BITS-1:0]  RST_SCALE_Y    = 16'd40;
	localparam logic [CENTER_BITS-1:0] RST_CENTER_COL = 8'd120;
	localparam logic [CENTER_BITS-1:0] RST_CENTER_ROW = 8'd40;

	localparam logic [7:0] RESULT_TOP = 8'd255;

	// digit width of the multiplier lanes
	localparam int MUL_DIGIT = 16;

	// coordinate queue between mapper and iterator
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef struct packed {
		logic [ITER_BITS-1:0]   max_iterations;
		logic [SCALE_BITS-1:0]  scale_x;
		logic [SCALE_BITS-1:0]  scale_y;
		logic [CENTER_BITS-1:0] center_col;
		logic [CENTER_BITS-1:0] center_row;
	} metp_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} metp_qstat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} metp_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_GO,
		B_MUL,
		B_CHK,
		B_UPD
	} metp_back_state_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_RUN,
		L_FIN
	} metp_lane_state_t;

endpackage

>>> design/metp_div.sv
`timescale 1ns / 1ps
// restoring radix-2 divider, one quotient bit per cycle, saturating quotient
// depends on metp_pkg

module metp_div import metp_pkg::*; #(
	parameter int NUM_W = 32,
	parameter int MAG_W = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [SCALE_BITS-1:0] den,
	output logic                  done,
	output logic [MAG_W-1:0]      quo
);

	localparam int CW = $clog2(NUM_W);

	logic                  run_q;
	logic [CW-1:0]         cnt_q;
	logic [NUM_W-1:0]      sh_q;
	logic [SCALE_BITS-1:0] rem_q;
	logic [SCALE_BITS-1:0] den_q;

	logic [SCALE_BITS:0]   trial;
	logic                  ge;
	logic [SCALE_BITS:0]   diff;

	assign trial = {rem_q, sh_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign done  = run_q && (cnt_q == CW'(NUM_W - 1));

	// quotient bits above the fixed-point range clip to full scale
	assign quo = (|sh_q[NUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : sh_q[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			run_q <= !done;
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			sh_q  <= {sh_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[SCALE_BITS-1:0] : trial[SCALE_BITS-1:0];
		end
	end

endmodule

>>> design/metp_front.sv
`timescale 1ns / 1ps
// front end: takes a pixel beat and maps it to the fixed-point point c
// depends on metp_pkg and metp_div

module metp_front import metp_pkg::*; #(
	parameter int COORD_BITS    = 8,
	parameter int FRACTION_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [COORD_BITS-1:0]   pixel_col,
	input  logic [COORD_BITS-1:0]   pixel_row,
	input  metp_cfg_t               cfg,
	input  metp_qstat_t             qstat,
	output logic                    push,
	output logic [2*(FRACTION_BITS+8)-1:0] push_data
);

	localparam int W     = FRACTION_BITS + 8;
	localparam int M     = FRACTION_BITS + 7;
	localparam int PB    = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 1;
	localparam int NUM_W = PB - 1 + FRACTION_BITS;

	metp_front_state_t state_q, state_d;

	logic                  div_start;
	logic                  done_x;
	logic                  done_y;
	logic [M-1:0]          quo_x;
	logic [M-1:0]          quo_y;
	logic [PB-1:0]         dx;
	logic [PB-1:0]         dy;
	logic [PB-1:0]         ndx;
	logic [PB-1:0]         ndy;
	logic [PB-2:0]         mag_x;
	logic [PB-2:0]         mag_y;
	logic [NUM_W-1:0]      num_x;
	logic [NUM_W-1:0]      num_y;
	logic [SCALE_BITS-1:0] den_x;
	logic [SCALE_BITS-1:0] den_y;
	logic                  neg_x_q;
	logic                  neg_y_q;
	logic [W-1:0]          c1;
	logic [W-1:0]          c2;

	assign dx = {{(PB-COORD_BITS){1'b0}}, pixel_col} - {{(PB-CENTER_BITS){1'b0}}, cfg.center_col};
	assign dy = {{(PB-COORD_BITS){1'b0}}, pixel_row} - {{(PB-CENTER_BITS){1'b0}}, cfg.center_row};
	assign ndx = -dx;
	assign ndy = -dy;
	assign mag_x = dx[PB-1] ? ndx[PB-2:0] : dx[PB-2:0];
	assign mag_y = dy[PB-1] ? ndy[PB-2:0] : dy[PB-2:0];
	assign num_x = {mag_x, {FRACTION_BITS{1'b0}}};
	assign num_y = {mag_y, {FRACTION_BITS{1'b0}}};

	// a zero scale divides by one
	assign den_x = (cfg.scale_x == '0) ? SCALE_BITS'(1) : cfg.scale_x;
	assign den_y = (cfg.scale_y == '0) ? SCALE_BITS'(1) : cfg.scale_y;

	metp_div #(.NUM_W(NUM_W), .MAG_W(M)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_x),
		.den    (den_x),
		.done   (done_x),
		.quo    (quo_x)
	);

	metp_div #(.NUM_W(NUM_W), .MAG_W(M)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_y),
		.den    (den_y),
		.done   (done_y),
		.quo    (quo_y)
	);

	assign c1 = neg_x_q ? W'(-{1'b0, quo_x}) : {1'b0, quo_x};
	assign c2 = neg_y_q ? W'(-{1'b0, quo_y}) : {1'b0, quo_y};
	assign push_data = {c1, c2};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (start) state_d = F_DIV;
			F_DIV:  if (done_x && done_y) state_d = F_PUSH;
			F_PUSH: if (!qstat.full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy      = state_q != F_IDLE;
		div_start = (state_q == F_IDLE) && start;
		push      = (state_q == F_PUSH) && !qstat.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_x_q <= dx[PB-1];
			neg_y_q <= dy[PB-1];
		end
	end

endmodule

>>> design/metp_queue.sv
`timescale 1ns / 1ps
// short fifo of mapped points between the front and back ends
// depends on metp_pkg

module metp_queue import metp_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output metp_qstat_t      stat
);

	logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> design/metp_mul_lane.sv
`timescale 1ns / 1ps
// signed fixed-point multiplier lane: magnitude times one digit per cycle,
// then truncation, saturation and sign; depends on metp_pkg

module metp_mul_lane import metp_pkg::*; #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [FRACTION_BITS+7:0]  a,
	input  logic signed [FRACTION_BITS+7:0]  b,
	output logic                             done,
	output logic signed [FRACTION_BITS+7:0]  res
);

	localparam int W  = FRACTION_BITS + 8;
	localparam int M  = FRACTION_BITS + 7;
	localparam int D  = MUL_DIGIT;
	localparam int ND = (M + D - 1) / D;
	localparam int PW = M + ND * D;
	localparam int CW = $clog2(ND);

	metp_lane_state_t state_q, state_d;

	logic [CW-1:0]       cnt_q;
	logic [M-1:0]        a_q;
	logic [ND*D-1:0]     b_q;
	logic [M+D-1:0]      acc_q;
	logic [(ND-1)*D-1:0] lo_q;
	logic                neg_q;
	logic signed [W-1:0] res_q;

	logic [W-1:0]        abs_a;
	logic [W-1:0]        abs_b;
	logic [M+D-1:0]      pp;
	logic [M+D-1:0]      acc_d;
	logic [ND*D-1:0]     lo_cat;
	logic [PW-1:0]       prod;
	logic [M-1:0]        q_mag;
	logic [W-1:0]        res_c;
	logic                last;

	assign abs_a = a[W-1] ? W'(-a) : W'(a);
	assign abs_b = b[W-1] ? W'(-b) : W'(b);

	assign pp     = (M+D)'(a_q) * (M+D)'(b_q[D-1:0]);
	assign acc_d  = (acc_q >> D) + pp;
	// low digit of the accumulator retires into the low product bits
	assign lo_cat = {acc_q[D-1:0], lo_q};
	assign prod   = {acc_q, lo_q};
	assign q_mag  = (|prod[PW-1:FRACTION_BITS+M]) ? {M{1'b1}} :
	                prod[FRACTION_BITS+M-1:FRACTION_BITS];
	assign res_c  = neg_q ? W'(-{1'b0, q_mag}) : {1'b0, q_mag};
	assign last   = cnt_q == CW'(ND - 1);
	assign res    = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_IDLE:  if (start) state_d = L_RUN;
			L_RUN:   if (last) state_d = L_FIN;
			L_FIN:   state_d = L_IDLE;
			default: state_d = L_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == L_FIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == L_RUN) cnt_q <= cnt_q + CW'(1);
			else                  cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				if (start) begin
					a_q   <= abs_a[M-1:0];
					b_q   <= (ND*D)'(abs_b[M-1:0]);
					acc_q <= '0;
					neg_q <= a[W-1] ^ b[W-1];
				end
			end
			L_RUN: begin
				acc_q <= acc_d;
				lo_q  <= lo_cat[ND*D-1:D];
				b_q   <= b_q >> D;
			end
			L_FIN: begin
				res_q <= res_c;
			end
			default: ;
		endcase
	end

endmodule

>>> design/metp_back.sv
`timescale 1ns / 1ps
// back end: iterates z = z^2 + c on three multiplier lanes and forms the result
// depends on metp_pkg and metp_mul_lane

module metp_back import metp_pkg::*; #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ITER_BITS-1:0]          max_iterations,
	input  metp_qstat_t                   qstat,
	input  logic [2*(FRACTION_BITS+8)-1:0] pop_data,
	output logic                          pop,
	output logic                          done,
	output logic [7:0]                    escape_value
);

	localparam int W = FRACTION_BITS + 8;
	localparam int M = FRACTION_BITS + 7;

	localparam logic signed [W:0]   SUM_MAX = {2'b00, {M{1'b1}}};
	localparam logic signed [W:0]   SUM_MIN = -SUM_MAX;
	localparam logic signed [W-1:0] FX_FOUR = {8'd4, {FRACTION_BITS{1'b0}}};

	function automatic logic signed [W:0] sx(input logic signed [W-1:0] v);
		return {v[W-1], v};
	endfunction

	function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] s);
		priority if (s > SUM_MAX) return SUM_MAX[W-1:0];
		else if (s < SUM_MIN)     return SUM_MIN[W-1:0];
		else                      return s[W-1:0];
	endfunction

	metp_back_state_t state_q, state_d;

	logic signed [W-1:0]  c1_q, c2_q;
	logic signed [W-1:0]  x1_q, x2_q;
	logic signed [W-1:0]  mag_q, dif_q, dbl_q;
	logic [ITER_BITS-1:0] idx_q;
	logic                 done_q;
	logic [7:0]           esc_q;

	logic                 lane_start;
	logic [2:0]           lane_done;
	logic signed [W-1:0]  s1, s2, pr;
	logic                 escaped;
	logic                 finish;
	logic [7:0]           final_val;
	logic [7:0]           result;

	metp_mul_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_re (
		.clk(clk), .arst_n(arst_n), .start(lane_start),
		.a(x1_q), .b(x1_q), .done(lane_done[0]), .res(s1)
	);

	metp_mul_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_im (
		.clk(clk), .arst_n(arst_n), .start(lane_start),
		.a(x2_q), .b(x2_q), .done(lane_done[1]), .res(s2)
	);

	metp_mul_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_cross (
		.clk(clk), .arst_n(arst_n), .start(lane_start),
		.a(x1_q), .b(x2_q), .done(lane_done[2]), .res(pr)
	);

	// squares of the current z give both the escape test and the next step
	assign escaped   = mag_q >= FX_FOUR;
	assign final_val = RESULT_TOP - {1'b0, mag_q[W-2:FRACTION_BITS]};
	assign finish    = (max_iterations == '0) || escaped ||
	                   ((idx_q + ITER_BITS'(1)) == max_iterations);

	always_comb begin
		priority if (max_iterations == '0) result = final_val;
		else if (escaped)                  result = idx_q;
		else                               result = final_val;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (!qstat.empty) state_d = B_GO;
			B_GO:    state_d = B_MUL;
			B_MUL:   if (&lane_done) state_d = B_CHK;
			B_CHK:   state_d = B_UPD;
			B_UPD:   state_d = finish ? B_IDLE : B_GO;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop        = (state_q == B_IDLE) && !qstat.empty;
		lane_start = state_q == B_GO;
	end

	assign done         = done_q;
	assign escape_value = esc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == B_UPD) && finish;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					c1_q  <= pop_data[2*W-1:W];
					c2_q  <= pop_data[W-1:0];
					// the first step from z = 0 lands exactly on c
					x1_q  <= pop_data[2*W-1:W];
					x2_q  <= pop_data[W-1:0];
					idx_q <= '0;
				end
			end
			B_CHK: begin
				mag_q <= sat_sum(sx(s1) + sx(s2));
				dif_q <= sat_sum(sx(s1) - sx(s2));
				dbl_q <= sat_sum({pr, 1'b0});
			end
			B_UPD: begin
				if (finish) begin
					esc_q <= result;
				end else begin
					x1_q  <= sat_sum(sx(dif_q) + sx(c1_q));
					x2_q  <= sat_sum(sx(dbl_q) + sx(c2_q));
					idx_q <= idx_q + ITER_BITS'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

>>> design/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// top level of the mandelbrot escape-time pixel evaluator: register file,
// coordinate mapper, point queue and iterator; depends on metp_pkg and submodules
//
//  channel   signals                            beat taken when
//  config    wr_en, wr_index, wr_data           wr_en high
//  pixel     start, busy, pixel_col, pixel_row  start high and busy low
//  result    done, escape_value                 done high (one cycle)
//
// mapping runs the two bit-serial dividers, one per axis, side by side; busy stays high
// through it until the mapped point is pushed into the queue.
// each iteration step starts the three digit-serial multiplier lanes, waits for all of
// them, then forms the squared magnitude and either updates z or takes the result.
// a two-entry queue lets mapping of the next pixels overlap iteration of the current one.
// reset is asynchronous and clears all control state; the result side has no stall.

module mandelbrot_escape_time_pixel import metp_pkg::*; #(
	parameter int COORD_BITS    = 8,
	parameter int FRACTION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [REG_IDX_BITS-1:0]  wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [COORD_BITS-1:0]    pixel_col,
	input  logic [COORD_BITS-1:0]    pixel_row,
	output logic                     done,
	output logic [7:0]               escape_value
);

	localparam int W = FRACTION_BITS + 8;

	metp_cfg_t     cfg_q;
	metp_qstat_t   qstat;
	logic          push;
	logic          pop;
	logic [2*W-1:0] push_data;
	logic [2*W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_iterations <= RST_MAX_ITER;
			cfg_q.scale_x        <= RST_SCALE_X;
			cfg_q.scale_y        <= RST_SCALE_Y;
			cfg_q.center_col     <= RST_CENTER_COL;
			cfg_q.center_row     <= RST_CENTER_ROW;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_ITER:   cfg_q.max_iterations <= wr_data[ITER_BITS-1:0];
				REG_SCALE_X:    cfg_q.scale_x        <= wr_data[SCALE_BITS-1:0];
				REG_SCALE_Y:    cfg_q.scale_y        <= wr_data[SCALE_BITS-1:0];
				REG_CENTER_COL: cfg_q.center_col     <= wr_data[CENTER_BITS-1:0];
				REG_CENTER_ROW: cfg_q.center_row     <= wr_data[CENTER_BITS-1:0];
				default: ;
			endcase
		end
	end

	metp_front #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.cfg       (cfg_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	metp_queue #(.WIDTH(2*W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	metp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_iterations (cfg_q.max_iterations),
		.qstat          (qstat),
		.pop_data       (pop_data),
		.pop            (pop),
		.done           (done),
		.escape_value   (escape_value)
	);

endmodule

>>> design/metp_checker.sv
`timescale 1ns / 1ps
// port-level checker for the mandelbrot escape-time pixel block, with its bind
// depends on mandelbrot_escape_time_pixel

module metp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// pixel beats taken but not yet answered
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b00, start && !busy} - {2'b00, done};
		end
	end

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !busy && !done)
		else $error("busy or done high during reset");

	a_map_holds_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy ##1 busy)
		else $error("mapper released busy too early");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pend_q != 3'd0)
		else $error("result without an outstanding pixel");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more pixels in flight than the design can hold");

endmodule

bind mandelbrot_escape_time_pixel metp_checker u_metp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

>>> tb/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// self-checking testbench for mandelbrot_escape_time_pixel: directed and random pixels
// over several register settings, checked against a fixed-point escape-time predictor
// depends on metp_pkg and the design files

module tb_mandelbrot_escape_time_pixel;
	import metp_pkg::*;

	localparam int     COORD   = 8;
	localparam int     FRAC    = 24;
	localparam longint FX_MAX  = (longint'(1) << (FRAC + 7)) - 1;
	localparam longint FX_FOUR = longint'(4) << FRAC;
	localparam int     MAX_GAP = 120;
	localparam int     SETTLE  = 40;

	typedef struct packed {
		logic [COORD-1:0] col;
		logic [COORD-1:0] row;
	} pixel_beat_t;

	typedef struct {
		logic [COORD-1:0] col;
		logic [COORD-1:0] row;
		logic [7:0]       escape;
	} escape_expect_t;

	logic clk;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_BITS-1:0] wr_index = '0;
	logic [CFG_DATA_BITS-1:0] wr_data = '0;
	logic start = 1'b0;
	logic busy;
	logic [COORD-1:0] pixel_col = '0;
	logic [COORD-1:0] pixel_row = '0;
	logic done;
	logic [7:0] escape_value;

	// register copy used by the predictor
	logic [ITER_BITS-1:0]   cfg_max_iter   = RST_MAX_ITER;
	logic [SCALE_BITS-1:0]  cfg_scale_x    = RST_SCALE_X;
	logic [SCALE_BITS-1:0]  cfg_scale_y    = RST_SCALE_Y;
	logic [CENTER_BITS-1:0] cfg_center_col = RST_CENTER_COL;
	logic [CENTER_BITS-1:0] cfg_center_row = RST_CENTER_ROW;

	pixel_beat_t    pixel_queue[$];
	escape_expect_t escape_q[$];

	int unsigned issued_cnt = 0;
	int unsigned taken_cnt = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned settings_cnt = 1;
	int unsigned reg_writes = 0;
	int unsigned idle_left = 0;
	int unsigned run_left = 0;
	longint      budget = 1000;
	longint      cycle_cnt = 0;

	mandelbrot_escape_time_pixel #(
		.COORD_BITS(COORD),
		.FRACTION_BITS(FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.start(start),
		.busy(busy),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.done(done),
		.escape_value(escape_value)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint fx_clip(longint v);
		if (v > FX_MAX) return FX_MAX;
		if (v < -FX_MAX) return -FX_MAX;
		return v;
	endfunction

	// magnitude product, truncated toward zero, then signed and clipped
	function automatic longint fx_mul(longint a, longint b);
		bit [63:0] ma;
		bit [63:0] mb;
		bit [63:0] q;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		q = (ma * mb) >> FRAC;
		if (q > FX_MAX) q = FX_MAX;
		return ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint map_axis(logic [7:0] pix, logic [7:0] ctr, logic [15:0] scl);
		longint    d;
		bit [63:0] num;
		bit [63:0] q;
		bit [63:0] div;
		d = longint'(pix) - longint'(ctr);
		num = ((d < 0) ? -d : d);
		num = num << FRAC;
		// a zero scale divides by one
		div = (scl == 0) ? 64'd1 : 64'(scl);
		q = num / div;
		if (q > FX_MAX) q = FX_MAX;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [7:0] predict_escape(logic [COORD-1:0] col, logic [COORD-1:0] row);
		longint c_re;
		longint c_im;
		longint z_re = 0;
		longint z_im = 0;
		longint mag2;
		longint res;
		c_re = map_axis(col, cfg_center_col, cfg_scale_x);
		c_im = map_axis(row, cfg_center_row, cfg_scale_y);
		// with no steps the final point is c itself
		z_re = c_re;
		z_im = c_im;
		if (cfg_max_iter != 0) begin
			z_re = 0;
			z_im = 0;
		end
		for (int step = 0; step < int'(cfg_max_iter); step++) begin
			longint n_re;
			longint n_im;
			n_re = fx_clip(fx_clip(fx_mul(z_re, z_re) - fx_mul(z_im, z_im)) + c_re);
			n_im = fx_clip(fx_clip(2 * fx_mul(z_re, z_im)) + c_im);
			z_re = n_re;
			z_im = n_im;
			mag2 = fx_clip(fx_mul(z_re, z_re) + fx_mul(z_im, z_im));
			if (mag2 >= FX_FOUR) return step[7:0];
		end
		mag2 = fx_clip(fx_mul(z_re, z_re) + fx_mul(z_im, z_im));
		res = 255 - (mag2 >>> FRAC);
		if (res < 0) res = 0;
		if (res > 255) res = 255;
		return res[7:0];
	endfunction

	// pixel near the center along one axis, so that c mostly lands in the interesting area
	function automatic logic [7:0] pick_near(logic [7:0] ctr, logic [15:0] scl);
		int span;
		int lo;
		int hi;
		span = (scl > 102) ? 255 : int'(scl) * 5 / 2 + 1;
		lo = int'(ctr) - span;
		hi = int'(ctr) + span;
		if (lo < 0) lo = 0;
		if (hi > 255) hi = 255;
		return 8'($urandom_range(hi, lo));
	endfunction

	task automatic write_reg(input metp_reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_MAX_ITER:   cfg_max_iter = val[ITER_BITS-1:0];
			REG_SCALE_X:    cfg_scale_x = val[SCALE_BITS-1:0];
			REG_SCALE_Y:    cfg_scale_y = val[SCALE_BITS-1:0];
			REG_CENTER_COL: cfg_center_col = val[CENTER_BITS-1:0];
			REG_CENTER_ROW: cfg_center_row = val[CENTER_BITS-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic apply_settings(input logic [15:0] iters, input logic [15:0] sx,
			input logic [15:0] sy, input logic [15:0] cc, input logic [15:0] cr);
		write_reg(REG_MAX_ITER, iters);
		write_reg(REG_SCALE_X, sx);
		write_reg(REG_SCALE_Y, sy);
		write_reg(REG_CENTER_COL, cc);
		write_reg(REG_CENTER_ROW, cr);
		settings_cnt++;
	endtask

	task automatic queue_pixel(input logic [7:0] col, input logic [7:0] row);
		pixel_beat_t beat;
		beat.col = col;
		beat.row = row;
		pixel_queue.push_back(beat);
		budget += 64 + 6 * longint'(cfg_max_iter) + MAX_GAP;
	endtask

	// wait until every queued beat is taken and every result is back
	task automatic drain();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || issued_cnt != taken_cnt || escape_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk) begin : drive_pixels
		pixel_beat_t beat;
		int unsigned roll;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken_cnt == issued_cnt) begin
			if (idle_left != 0) begin
				idle_left--;
				start <= 1'b0;
				pixel_col <= COORD'($urandom);
				pixel_row <= COORD'($urandom);
			end else if (pixel_queue.size() != 0) begin
				beat = pixel_queue.pop_front();
				pixel_col <= beat.col;
				pixel_row <= beat.row;
				start <= 1'b1;
				issued_cnt++;
				// gap before the next beat: mostly none or short, some long, some bursts
				if (run_left != 0) begin
					run_left--;
				end else begin
					roll = $urandom_range(99, 0);
					if (roll < 5) run_left = $urandom_range(40, 10);
					else if (roll < 55) idle_left = 0;
					else if (roll < 90) idle_left = $urandom_range(4, 1);
					else idle_left = $urandom_range(MAX_GAP, 20);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		escape_expect_t pending;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				if (escape_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with nothing pending", escape_value);
				end else begin
					pending = escape_q.pop_front();
					if (escape_value !== pending.escape) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at pixel (%0d,%0d): escape_value expected %0d got %0d",
								pending.col, pending.row, pending.escape, escape_value);
					end
				end
			end
			if (start && !busy) begin
				pending.col = pixel_col;
				pending.row = pixel_row;
				pending.escape = predict_escape(pixel_col, pixel_row);
				escape_q.push_back(pending);
				taken_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > 4 * budget + 20000) begin
			$display("timeout after %0d cycles with %0d results pending", cycle_cnt,
				escape_q.size());
			$display("tb_mandelbrot_escape_time_pixel: FAIL");
			$finish;
		end
	end

	initial begin : run_test
		logic [15:0] iters;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] cc;
		logic [15:0] cr;
		int unsigned count;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: center, corners, real axis tips at -2 and 2, a point inside
		queue_pixel(120, 40);
		queue_pixel(0, 0);
		queue_pixel(255, 255);
		queue_pixel(0, 255);
		queue_pixel(255, 0);
		queue_pixel(100, 40);
		queue_pixel(200, 40);
		queue_pixel(40, 40);
		drain();

		// no steps, zero scale and unit scale: saturated c, zero c, small c
		apply_settings(16'd0, 16'd0, 16'd1, 16'd0, 16'd255);
		queue_pixel(255, 0);
		queue_pixel(0, 255);
		queue_pixel(1, 254);
		drain();

		// deepest run with the coarsest scale: c stays near zero for all steps
		apply_settings(16'd255, 16'hFFFF, 16'hFFFF, 16'd128, 16'd128);
		queue_pixel(0, 0);
		queue_pixel(255, 255);
		drain();

		// single step, upper data bits above the iteration register ignored
		apply_settings(16'h7F01, 16'd64, 16'd64, 16'd0, 16'd0);
		queue_pixel(128, 0);
		queue_pixel(96, 0);
		queue_pixel(0, 64);
		drain();

		for (int ph = 0; ph < 11; ph++) begin
			iters = ($urandom_range(7, 0) == 0) ? 16'd0 : 16'($urandom_range(64, 1));
			if (ph == 4) iters = 16'd255;
			sx = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(200, 16));
			sy = ($urandom_range(3, 0) == 0) ? 16'($urandom) : 16'($urandom_range(200, 16));
			cc = 16'($urandom_range(255, 0));
			cr = 16'($urandom_range(255, 0));
			apply_settings(iters, sx, sy, cc, cr);
			count = (ph == 4) ? 30 : 160;
			for (int k = 0; k < count; k++) begin
				if ($urandom_range(2, 0) == 0)
					queue_pixel(8'($urandom), 8'($urandom));
				else
					queue_pixel(pick_near(cfg_center_col, cfg_scale_x),
						pick_near(cfg_center_row, cfg_scale_y));
			end
			drain();
		end

		repeat (50) @(negedge clk);
		if (escape_q.size() != 0) begin
			$display("%0d expected results never arrived", escape_q.size());
			mismatches += escape_q.size();
		end

		$display("ran %0d pixel beats over %0d register settings (%0d register writes)",
			taken_cnt, settings_cnt, reg_writes);
		$display("checked %0d results, %0d mismatches, %0d cycles", results_seen, mismatches,
			cycle_cnt);
		if (mismatches == 0) begin
			$display("tb_mandelbrot_escape_time_pixel: PASS");
		end else begin
			$display("tb_mandelbrot_escape_time_pixel: FAIL");
		end
		$finish;
	end

endmodule
